### src/fpa_pkg.sv
// types and constants shared by the fixed-point alu modules
package fpa_pkg;

    localparam int DATA_W = 32;

    localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

    typedef enum logic [3:0] {
        CMD_ADD = 4'd0,
        CMD_SUB = 4'd1,
        CMD_MUL = 4'd2,
        CMD_DIV = 4'd3,
        CMD_MIN = 4'd4,
        CMD_MAX = 4'd5,
        CMD_INC = 4'd6,
        CMD_DEC = 4'd7,
        CMD_I2F = 4'd8,
        CMD_F2I = 4'd9
    } cmd_t;

    typedef struct packed {
        logic [3:0]               command;
        logic signed [DATA_W-1:0] operand_a;
        logic signed [DATA_W-1:0] operand_b;
    } fpa_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic                     divide_by_zero;
        logic                     saturated;
        logic                     a_less;
        logic                     a_equal;
        logic                     a_greater;
    } fpa_out_t;

    // side band that travels with each transaction down the divider chain
    typedef struct packed {
        logic                     valid;
        logic                     is_div;
        logic                     neg;
        logic signed [DATA_W-1:0] value;
        logic                     dz;
        logic                     sat;
        logic                     lt;
        logic                     eq;
        logic                     gt;
    } fpa_side_t;

endpackage

### src/fpa_front.sv
// front stages: decode, simple operations, multiply with rounding, divider operands
module fpa_front
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  fpa_in_t                     in_data,
    output fpa_side_t                   side_out,
    output logic [DATA_W+FRAC_BITS-1:0] nq_out,
    output logic [DATA_W-1:0]           den_out
);

    localparam int PROD_W = 2 * DATA_W;

    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic signed [DATA_W:0]   sum_ab;
    logic signed [DATA_W:0]   diff_ab;
    logic signed [DATA_W+FRAC_BITS-1:0] scaled_a;
    logic signed [PROD_W-1:0] prod;
    fpa_side_t                side1;

    fpa_side_t                s1_side_reg;
    logic signed [PROD_W-1:0] s1_prod_reg;
    logic                     s1_is_mul_reg;
    logic [DATA_W-1:0]        s1_abs_a_reg;
    logic [DATA_W-1:0]        s1_abs_b_reg;

    logic signed [PROD_W-1:0] mul_sum;
    logic signed [PROD_W-1:0] mul_shr;
    logic                     mul_fits;
    fpa_side_t                side2;

    fpa_side_t                          s2_side_reg;
    logic [DATA_W+FRAC_BITS-1:0]        s2_nq_reg;
    logic [DATA_W-1:0]                  s2_den_reg;

    assign a = in_data.operand_a;
    assign b = in_data.operand_b;

    assign sum_ab   = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    assign diff_ab  = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    assign scaled_a = {{FRAC_BITS{a[DATA_W-1]}}, a} <<< FRAC_BITS;
    // signed 32 by 32 product, operands sign extended to the product width
    assign prod     = PROD_W'(a) * PROD_W'(b);

    always_comb begin
        side1        = '0;
        side1.valid  = in_valid;
        side1.lt     = (a < b);
        side1.eq     = (a == b);
        side1.gt     = (a > b);
        side1.neg    = a[DATA_W-1] ^ b[DATA_W-1];
        case (cmd_t'(in_data.command))
            CMD_ADD: begin
                side1.sat   = (sum_ab[DATA_W] != sum_ab[DATA_W-1]);
                side1.value = side1.sat ? (sum_ab[DATA_W] ? S32_MIN : S32_MAX)
                                        : sum_ab[DATA_W-1:0];
            end
            CMD_SUB: begin
                side1.sat   = (diff_ab[DATA_W] != diff_ab[DATA_W-1]);
                side1.value = side1.sat ? (diff_ab[DATA_W] ? S32_MIN : S32_MAX)
                                        : diff_ab[DATA_W-1:0];
            end
            CMD_DIV: begin
                // zero divisor returns operand a unchanged
                side1.dz     = (b == '0);
                side1.is_div = (b != '0);
                side1.value  = a;
            end
            CMD_MIN: side1.value = (a < b) ? a : b;
            CMD_MAX: side1.value = (a > b) ? a : b;
            CMD_INC: begin
                side1.sat   = (a == S32_MAX);
                side1.value = side1.sat ? S32_MAX : a + 32'sd1;
            end
            CMD_DEC: begin
                side1.sat   = (a == S32_MIN);
                side1.value = side1.sat ? S32_MIN : a - 32'sd1;
            end
            CMD_I2F: begin
                side1.sat   = !((&scaled_a[DATA_W+FRAC_BITS-1:DATA_W-1]) ||
                                !(|scaled_a[DATA_W+FRAC_BITS-1:DATA_W-1]));
                side1.value = side1.sat ? (a[DATA_W-1] ? S32_MIN : S32_MAX)
                                        : scaled_a[DATA_W-1:0];
            end
            CMD_F2I: side1.value = a >>> FRAC_BITS;
            default: side1.value = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_side_reg.valid <= 1'b0;
        end else if (en) begin
            s1_side_reg <= side1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_prod_reg   <= prod;
            s1_is_mul_reg <= (cmd_t'(in_data.command) == CMD_MUL);
            s1_abs_a_reg  <= a[DATA_W-1] ? DATA_W'(-a) : DATA_W'(a);
            s1_abs_b_reg  <= b[DATA_W-1] ? DATA_W'(-b) : DATA_W'(b);
        end
    end

    // round half away from zero: add half, less one for negative products
    assign mul_sum  = s1_prod_reg + (PROD_W'(1) << (FRAC_BITS - 1))
                      - PROD_W'(s1_prod_reg[PROD_W-1]);
    assign mul_shr  = mul_sum >>> FRAC_BITS;
    assign mul_fits = (&mul_shr[PROD_W-1:DATA_W-1]) || !(|mul_shr[PROD_W-1:DATA_W-1]);

    always_comb begin
        side2 = s1_side_reg;
        if (s1_is_mul_reg) begin
            side2.sat   = !mul_fits;
            side2.value = mul_fits ? mul_shr[DATA_W-1:0]
                                   : (s1_prod_reg[PROD_W-1] ? S32_MIN : S32_MAX);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_side_reg.valid <= 1'b0;
        end else if (en) begin
            s2_side_reg <= side2;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_nq_reg  <= {s1_abs_a_reg, {FRAC_BITS{1'b0}}};
            s2_den_reg <= s1_abs_b_reg;
        end
    end

    assign side_out = s2_side_reg;
    assign nq_out   = s2_nq_reg;
    assign den_out  = s2_den_reg;

endmodule

### src/fpa_div_cell.sv
// one restoring divider cell: one quotient bit per transaction
module fpa_div_cell
    import fpa_pkg::*;
#(
    parameter int NQ_W = 40
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  fpa_side_t         side_in,
    input  logic [DATA_W-1:0] rem_in,
    input  logic [NQ_W-1:0]   nq_in,
    input  logic [DATA_W-1:0] den_in,
    output fpa_side_t         side_out,
    output logic [DATA_W-1:0] rem_out,
    output logic [NQ_W-1:0]   nq_out,
    output logic [DATA_W-1:0] den_out
);

    logic [DATA_W:0] trial;
    logic [DATA_W:0] diff;
    logic            ge;

    fpa_side_t         side_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [NQ_W-1:0]   nq_reg;
    logic [DATA_W-1:0] den_reg;

    // shift in the next numerator bit, subtract divisor if it fits
    assign trial = {rem_in, nq_in[NQ_W-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = !diff[DATA_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg.valid <= 1'b0;
        end else if (en) begin
            side_reg <= side_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
            nq_reg  <= {nq_in[NQ_W-2:0], ge};
            den_reg <= den_in;
        end
    end

    assign side_out = side_reg;
    assign rem_out  = rem_reg;
    assign nq_out   = nq_reg;
    assign den_out  = den_reg;

endmodule

### src/fpa_post.sv
// back end: quotient rounding, sign, saturation and result select
module fpa_post
    import fpa_pkg::*;
#(
    parameter int NQ_W = 40
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  fpa_side_t         side_in,
    input  logic [DATA_W-1:0] rem_in,
    input  logic [NQ_W-1:0]   nq_in,
    input  logic [DATA_W-1:0] den_in,
    output logic              out_valid,
    output fpa_out_t          out_data
);

    localparam logic [NQ_W:0] LIM_POS = (NQ_W+1)'(32'h7FFF_FFFF);
    localparam logic [NQ_W:0] LIM_NEG = LIM_POS + (NQ_W+1)'(1);

    logic          round_up;
    fpa_side_t     side_reg;
    logic [NQ_W:0] qr_reg;
    logic          q_sat;

    assign round_up = ({rem_in, 1'b0} >= {1'b0, den_in});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg.valid <= 1'b0;
        end else if (en) begin
            side_reg <= side_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            qr_reg <= {1'b0, nq_in} + (NQ_W+1)'(round_up);
        end
    end

    assign q_sat = side_reg.neg ? (qr_reg > LIM_NEG) : (qr_reg > LIM_POS);

    always_comb begin
        out_data.divide_by_zero = side_reg.dz;
        out_data.a_less         = side_reg.lt;
        out_data.a_equal        = side_reg.eq;
        out_data.a_greater      = side_reg.gt;
        if (side_reg.is_div) begin
            out_data.saturated = q_sat;
            if (q_sat) begin
                out_data.result_value = side_reg.neg ? S32_MIN : S32_MAX;
            end else if (side_reg.neg) begin
                out_data.result_value = -$signed(qr_reg[DATA_W-1:0]);
            end else begin
                out_data.result_value = $signed(qr_reg[DATA_W-1:0]);
            end
        end else begin
            out_data.saturated    = side_reg.sat;
            out_data.result_value = side_reg.value;
        end
    end

    assign out_valid = side_reg.valid;

endmodule

### src/fixed_point_alu.sv
// registers from input transaction to result valid: front stages, divider cells, post, output
// throughput: one per cycle unless skid is full; every command uses the same pipeline
// the divider is a chain of 32 + FRAC_BITS cells, one quotient bit in each cell
// a two-entry output register and skid stage let input go on while a result waits
// reset: aresetn, synchronous, active low; clears pipeline, output and skid valid bits
module fixed_point_alu
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  fpa_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output fpa_out_t m_data
);

    // quotient width: magnitude of operand a shifted up by the fraction bits
    localparam int NQ_W = DATA_W + FRAC_BITS;

    // pipeline advances whenever the skid stage is free
    logic en;

    fpa_side_t         side_chain [0:NQ_W];
    logic [DATA_W-1:0] rem_chain  [0:NQ_W];
    logic [NQ_W-1:0]   nq_chain   [0:NQ_W];
    logic [DATA_W-1:0] den_chain  [0:NQ_W];

    logic     pipe_valid;
    fpa_out_t pipe_data;

    logic     m_valid_reg;
    fpa_out_t m_data_reg;
    logic     skid_valid_reg;
    fpa_out_t skid_data_reg;

    assign en      = !skid_valid_reg;
    assign s_ready = en;

    // decode, simple ops and multiply
    fpa_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_valid),
        .in_data  (s_data),
        .side_out (side_chain[0]),
        .nq_out   (nq_chain[0]),
        .den_out  (den_chain[0])
    );

    // partial remainder starts at zero
    assign rem_chain[0] = '0;

    // divider chain, every transaction passes through all cells
    for (genvar i = 0; i < NQ_W; i++) begin : g_cell
        fpa_div_cell #(
            .NQ_W (NQ_W)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .side_in  (side_chain[i]),
            .rem_in   (rem_chain[i]),
            .nq_in    (nq_chain[i]),
            .den_in   (den_chain[i]),
            .side_out (side_chain[i+1]),
            .rem_out  (rem_chain[i+1]),
            .nq_out   (nq_chain[i+1]),
            .den_out  (den_chain[i+1])
        );
    end

    // rounding and final select
    fpa_post #(
        .NQ_W (NQ_W)
    ) u_post (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .side_in   (side_chain[NQ_W]),
        .rem_in    (rem_chain[NQ_W]),
        .nq_in     (nq_chain[NQ_W]),
        .den_in    (den_chain[NQ_W]),
        .out_valid (pipe_valid),
        .out_data  (pipe_data)
    );

    // output register with skid: a stalled result parks the next one in the skid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            // pipeline frozen, skid moves up once the output is taken
            if (m_ready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (m_valid_reg && !m_ready) begin
            if (pipe_valid) begin
                skid_valid_reg <= 1'b1;
            end
        end else begin
            m_valid_reg <= pipe_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_ready) begin
                m_data_reg <= skid_data_reg;
            end
        end else if (m_valid_reg && !m_ready) begin
            skid_data_reg <= pipe_data;
        end else begin
            m_data_reg <= pipe_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a parked result always sits behind a valid output
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid holds data while output register is empty");

    // skid drains in the cycle after the output is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && m_ready |=> !skid_valid_reg && m_valid_reg)
        else $error("skid did not drain into output register");

    // compare flags are exclusive on every result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> $onehot({m_data_reg.a_less, m_data_reg.a_equal,
                                 m_data_reg.a_greater}))
        else $error("compare flags not one-hot");

    // a divide by zero never reports saturation
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.divide_by_zero |-> !m_data_reg.saturated)
        else $error("divide by zero flagged as saturated");

endmodule
